// File: rtl/epc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Epoch calendar converter package
// Shared item types, calendar constants, month tables and the control and
// status records that pass between the sequencer and the serial divider.
// ----------------------------------------------------------------------------
package epc_pkg;

   localparam int DIV_WIDTH = 48;

   localparam logic [26:0] MS_PER_DAY  = 27'd86400000;
   localparam logic [26:0] MS_PER_HOUR = 27'd3600000;
   localparam logic [26:0] MS_PER_MIN  = 27'd60000;
   localparam logic [26:0] MS_PER_SEC  = 27'd1000;
   localparam logic [26:0] DAYS_400Y   = 27'd146097;
   localparam logic [26:0] DAYS_100Y   = 27'd36524;
   localparam logic [26:0] DAYS_4Y     = 27'd1461;
   localparam logic [26:0] DAYS_1Y     = 27'd365;
   localparam logic [26:0] YEARS_100   = 27'd100;

   // Days from 1601-01-01 to 1970-01-01.
   localparam logic [23:0] DAYS_1601_TO_1970 = 24'd134774;

   localparam logic [13:0] YEAR_MIN   = 14'd1970;
   localparam logic [13:0] YEAR_MAX   = 14'd9999;
   localparam logic [13:0] YEAR_CYCLE = 14'd1601;

   typedef struct packed {
      logic        mode;
      logic [47:0] stamp_in;
      logic [13:0] year_in;
      logic [3:0]  month_in;
      logic [4:0]  day_in;
      logic [4:0]  hour_in;
      logic [5:0]  minute_in;
      logic [5:0]  second_in;
      logic [9:0]  milli_in;
   } req_item_type;

   typedef struct packed {
      logic [47:0] stamp_out;
      logic [13:0] year_out;
      logic [3:0]  month_out;
      logic [4:0]  day_out;
      logic [4:0]  hour_out;
      logic [5:0]  minute_out;
      logic [5:0]  second_out;
      logic [9:0]  milli_out;
      logic        leap_flag;
      logic [8:0]  day_of_year;
      logic [21:0] day_count;
   } rsp_item_type;

   typedef struct packed {
      logic        start;
      logic [5:0]  nbits;
      logic [26:0] divisor;
   } div_ctl_type;

   typedef struct packed {
      logic        done;
      logic [21:0] quot;
      logic [26:0] rem;
   } div_stat_type;

   // First day of each month in a common year, zero based.
   function automatic logic [8:0] month_start(input logic [3:0] idx);
      case (idx)
         4'd0:    month_start = 9'd0;
         4'd1:    month_start = 9'd31;
         4'd2:    month_start = 9'd59;
         4'd3:    month_start = 9'd90;
         4'd4:    month_start = 9'd120;
         4'd5:    month_start = 9'd151;
         4'd6:    month_start = 9'd181;
         4'd7:    month_start = 9'd212;
         4'd8:    month_start = 9'd243;
         4'd9:    month_start = 9'd273;
         4'd10:   month_start = 9'd304;
         4'd11:   month_start = 9'd334;
         default: month_start = 9'd0;
      endcase
   endfunction

   // Largest day accepted on input; February always takes 29.
   function automatic logic [4:0] month_max_day(input logic [3:0] idx);
      case (idx)
         4'd1:                      month_max_day = 5'd29;
         4'd3, 4'd5, 4'd8, 4'd10:   month_max_day = 5'd30;
         default:                   month_max_day = 5'd31;
      endcase
   endfunction

endpackage

// File: rtl/epc_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Epoch calendar stream interface
// Valid/ready channel carrying one item per transfer.
// ----------------------------------------------------------------------------
interface epc_stream_if #(parameter type item_type = logic);
   logic     valid;
   logic     ready;
   item_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/epc_serdiv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial restoring divider
// Produces one quotient bit per cycle for a caller-chosen quotient length.
// ----------------------------------------------------------------------------
module epc_serdiv
   import epc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  div_ctl_type  ctl,
   input  logic [47:0]  dividend,
   output div_stat_type stat
);

   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [26:0] rem_ff;
   logic [47:0] sh_ff;
   logic [21:0] quot_ff;
   logic [26:0] div_ff;
   logic [27:0] trial;
   logic        fits;

   // The caller guarantees the quotient fits nbits, so the bits above the
   // shift window are already smaller than the divisor.
   assign trial = {rem_ff, sh_ff[47]};
   assign fits  = trial >= {1'b0, div_ff};

   always_comb begin
      run_in  = run_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         run_in = 1'b1;
         cnt_in = ctl.nbits;
      end else if (run_ff) begin
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 6'd0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         rem_ff  <= 27'(dividend >> ctl.nbits);
         sh_ff   <= dividend << (6'(DIV_WIDTH) - ctl.nbits);
         quot_ff <= 22'd0;
         div_ff  <= ctl.divisor;
      end else if (run_ff) begin
         rem_ff  <= fits ? 27'(trial - {1'b0, div_ff}) : trial[26:0];
         sh_ff   <= {sh_ff[46:0], 1'b0};
         quot_ff <= {quot_ff[20:0], fits};
      end
   end

   assign stat.done = done_ff;
   assign stat.quot = quot_ff;
   assign stat.rem  = rem_ff;

endmodule

// File: rtl/epoch_ms_calendar_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Epoch millisecond calendar converter
// Converts milliseconds since 1970-01-01 to Gregorian fields and back.
// ----------------------------------------------------------------------------
// One item is in work at a time; req_chan is ready whenever the sequencer is
// idle, even while a finished result still waits on rsp_chan. A decode item
// passes from its acceptance to its result on rsp_chan through a launch
// step, the division by the day length, the divisions for hours, minutes and
// seconds, the divisions for the 400, 100, 4 and 1 year periods, a pick-up
// step after each of the eight divisions in which its result is taken and
// the next one is launched, and the month lookup. All divisions share one
// serial restoring divider. A compose item first passes through a launch
// step, the division for the century of the year and its pick-up step, and
// 4 multiply-add steps that build the timestamp, before that decode. A new
// request can be accepted in the same cycle as the result appears; the
// month lookup holds a result until the previous result has been taken or
// is taken in that same cycle.
module epoch_ms_calendar_converter
   import epc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   epc_stream_if.sink    req_chan,
   epc_stream_if.source  rsp_chan
);

   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_CGO  = 5'd1;
   localparam logic [4:0] S_CYR  = 5'd2;
   localparam logic [4:0] S_CH   = 5'd3;
   localparam logic [4:0] S_CM   = 5'd4;
   localparam logic [4:0] S_CS   = 5'd5;
   localparam logic [4:0] S_CMS  = 5'd6;
   localparam logic [4:0] S_DGO  = 5'd7;
   localparam logic [4:0] S_DDAY = 5'd8;
   localparam logic [4:0] S_DHR  = 5'd9;
   localparam logic [4:0] S_DMIN = 5'd10;
   localparam logic [4:0] S_DSEC = 5'd11;
   localparam logic [4:0] S_Q400 = 5'd12;
   localparam logic [4:0] S_Q100 = 5'd13;
   localparam logic [4:0] S_Q4   = 5'd14;
   localparam logic [4:0] S_Q1   = 5'd15;
   localparam logic [4:0] S_CAL  = 5'd16;

   logic [4:0]   state_ff, state_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_ff;

   // Latched compose fields; year, month and day are already clamped.
   logic [13:0] yc_ff;
   logic [3:0]  mc_ff;
   logic [4:0]  dc_ff;
   logic [4:0]  h_ff;
   logic [5:0]  mi_ff;
   logic [5:0]  s_ff;
   logic [9:0]  ms_ff;

   logic [47:0] acc_ff;
   logic [47:0] t_ff;
   logic [21:0] days_ff;
   logic [4:0]  hour_ff;
   logic [5:0]  min_ff;
   logic [5:0]  sec_ff;
   logic [9:0]  milli_ff;
   logic [4:0]  q400_ff;
   logic [1:0]  q100_ff;
   logic [4:0]  q4_ff;
   logic [13:0] year_ff;
   logic        leap_ff;
   logic [8:0]  doy_ff;

   div_ctl_type  dctl;
   div_stat_type dstat;
   logic [47:0]  dividend;

   logic         accept;
   logic         rsp_free;

   logic [3:0]   m_clamp;
   logic [4:0]   d_clamp;
   logic [13:0]  y_clamp;

   logic [13:0]  cy_off;
   logic [6:0]   cq100;
   logic [6:0]   cq400;
   logic         cleap;
   logic [23:0]  cdays;

   logic [1:0]   q100_c;
   logic [26:0]  r100_c;
   logic [1:0]   q1_c;
   logic [8:0]   doy_c;
   logic [13:0]  year_c;
   logic         leap_c;

   logic [3:0]   mon_idx;
   logic [8:0]   mon_start;
   logic [8:0]   s_try;
   logic [4:0]   dom;

   epc_serdiv u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (dctl),
      .dividend (dividend),
      .stat     (dstat)
   );

   assign req_chan.ready = (state_ff == S_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_ff;

   // Input clamping for compose: bad month becomes January, bad day becomes
   // the first, and the year is held to the supported range.
   always_comb begin
      m_clamp = req_chan.data.month_in;
      if (m_clamp < 4'd1 || m_clamp > 4'd12) begin
         m_clamp = 4'd1;
      end
      d_clamp = req_chan.data.day_in;
      if (d_clamp == 5'd0 || d_clamp > month_max_day(m_clamp - 4'd1)) begin
         d_clamp = 5'd1;
      end
      y_clamp = req_chan.data.year_in;
      if (y_clamp < YEAR_MIN) begin
         y_clamp = YEAR_MIN;
      end else if (y_clamp > YEAR_MAX) begin
         y_clamp = YEAR_MAX;
      end
   end

   // Day count of a composed date. The divider has produced (year-1)/100
   // and its remainder; counting from 1601 the century terms drop out of
   // that quotient directly.
   always_comb begin
      cy_off = yc_ff - YEAR_CYCLE;
      cq100  = dstat.quot[6:0] - 7'd16;
      cq400  = cq100 >> 2;
      cleap  = (yc_ff[1:0] == 2'b00) &&
               ((dstat.rem[6:0] != 7'd99) || (dstat.quot[1:0] == 2'b11));
      cdays  = 24'(cy_off) * 24'd365 + 24'(cy_off >> 2) - 24'(cq100) + 24'(cq400)
             - DAYS_1601_TO_1970 + 24'(month_start(mc_ff - 4'd1))
             + 24'(dc_ff) - 24'd1 + 24'(mc_ff > 4'd2 && cleap);
   end

   // The last century of a 400 year cycle and the last year of a 4 year cycle
   // are one day longer, so a quotient of four is folded back to three.
   always_comb begin
      if (dstat.quot[2:0] == 3'd4) begin
         q100_c = 2'd3;
         r100_c = dstat.rem + DAYS_100Y;
      end else begin
         q100_c = dstat.quot[1:0];
         r100_c = dstat.rem;
      end
      if (dstat.quot[2:0] == 3'd4) begin
         q1_c  = 2'd3;
         doy_c = dstat.rem[8:0] + 9'd365;
      end else begin
         q1_c  = dstat.quot[1:0];
         doy_c = dstat.rem[8:0];
      end
      year_c = YEAR_CYCLE + 14'(q400_ff) * 14'd400 + 14'(q100_ff) * 14'd100
             + 14'(q4_ff) * 14'd4 + 14'(q1_c);
      leap_c = (q1_c == 2'd3) && ((q4_ff != 5'd24) || (q100_ff == 2'd3));
   end

   // Month lookup: the last month whose start is not past the day of year.
   always_comb begin
      mon_idx   = 4'd0;
      mon_start = 9'd0;
      s_try     = 9'd0;
      for (int i = 0; i < 12; i++) begin
         s_try = month_start(4'(i)) + ((i >= 2) ? 9'(leap_ff) : 9'd0);
         if (doy_ff >= s_try) begin
            mon_idx   = 4'(i);
            mon_start = s_try;
         end
      end
      dom = 5'(doy_ff - mon_start + 9'd1);
   end

   // Divider launches. Each later phase starts in the cycle the previous one
   // reports done, dividing its remainder (folded for 4 years, days for 400).
   always_comb begin
      dctl     = '0;
      dividend = 48'd0;
      case (state_ff)
         S_CGO: begin
            dctl.start   = 1'b1;
            dctl.nbits   = 6'd7;
            dctl.divisor = YEARS_100;
            dividend     = 48'(yc_ff - 14'd1);
         end
         S_DGO: begin
            dctl.start   = 1'b1;
            dctl.nbits   = 6'd48;
            dctl.divisor = MS_PER_DAY;
            dividend     = t_ff;
         end
         S_DDAY: begin
            dctl.start   = dstat.done;
            dctl.nbits   = 6'd5;
            dctl.divisor = MS_PER_HOUR;
            dividend     = 48'(dstat.rem);
         end
         S_DHR: begin
            dctl.start   = dstat.done;
            dctl.nbits   = 6'd6;
            dctl.divisor = MS_PER_MIN;
            dividend     = 48'(dstat.rem);
         end
         S_DMIN: begin
            dctl.start   = dstat.done;
            dctl.nbits   = 6'd6;
            dctl.divisor = MS_PER_SEC;
            dividend     = 48'(dstat.rem);
         end
         S_DSEC: begin
            dctl.start   = dstat.done;
            dctl.nbits   = 6'd5;
            dctl.divisor = DAYS_400Y;
            dividend     = 48'(24'(days_ff) + DAYS_1601_TO_1970);
         end
         S_Q400: begin
            dctl.start   = dstat.done;
            dctl.nbits   = 6'd3;
            dctl.divisor = DAYS_100Y;
            dividend     = 48'(dstat.rem);
         end
         S_Q100: begin
            dctl.start   = dstat.done;
            dctl.nbits   = 6'd5;
            dctl.divisor = DAYS_4Y;
            dividend     = 48'(r100_c);
         end
         S_Q4: begin
            dctl.start   = dstat.done;
            dctl.nbits   = 6'd3;
            dctl.divisor = DAYS_1Y;
            dividend     = 48'(dstat.rem);
         end
         default: begin
            dctl     = '0;
            dividend = 48'd0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = req_chan.data.mode ? S_CGO : S_DGO;
            end
         end
         S_CGO:  state_in = S_CYR;
         S_CYR: begin
            if (dstat.done) begin
               state_in = S_CH;
            end
         end
         S_CH:   state_in = S_CM;
         S_CM:   state_in = S_CS;
         S_CS:   state_in = S_CMS;
         S_CMS:  state_in = S_DGO;
         S_DGO:  state_in = S_DDAY;
         S_DDAY: if (dstat.done) state_in = S_DHR;
         S_DHR:  if (dstat.done) state_in = S_DMIN;
         S_DMIN: if (dstat.done) state_in = S_DSEC;
         S_DSEC: if (dstat.done) state_in = S_Q400;
         S_Q400: if (dstat.done) state_in = S_Q100;
         S_Q100: if (dstat.done) state_in = S_Q4;
         S_Q4:   if (dstat.done) state_in = S_Q1;
         S_Q1:   if (dstat.done) state_in = S_CAL;
         S_CAL: begin
            if (rsp_free) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         t_ff  <= req_chan.data.stamp_in;
         yc_ff <= y_clamp;
         mc_ff <= m_clamp;
         dc_ff <= d_clamp;
         h_ff  <= req_chan.data.hour_in;
         mi_ff <= req_chan.data.minute_in;
         s_ff  <= req_chan.data.second_in;
         ms_ff <= req_chan.data.milli_in;
      end
      // Timestamp built by Horner steps: days, hours, minutes, seconds, ms.
      if (state_ff == S_CYR && dstat.done) begin
         acc_ff <= 48'(cdays[21:0]);
      end
      if (state_ff == S_CH) begin
         acc_ff <= acc_ff * 48'd24 + 48'(h_ff);
      end
      if (state_ff == S_CM) begin
         acc_ff <= acc_ff * 48'd60 + 48'(mi_ff);
      end
      if (state_ff == S_CS) begin
         acc_ff <= acc_ff * 48'd60 + 48'(s_ff);
      end
      if (state_ff == S_CMS) begin
         t_ff <= acc_ff * 48'd1000 + 48'(ms_ff);
      end
      if (dstat.done) begin
         case (state_ff)
            S_DDAY: days_ff <= dstat.quot;
            S_DHR:  hour_ff <= dstat.quot[4:0];
            S_DMIN: min_ff  <= dstat.quot[5:0];
            S_DSEC: begin
               sec_ff   <= dstat.quot[5:0];
               milli_ff <= dstat.rem[9:0];
            end
            S_Q400: q400_ff <= dstat.quot[4:0];
            S_Q100: q100_ff <= q100_c;
            S_Q4:   q4_ff   <= dstat.quot[4:0];
            S_Q1: begin
               year_ff <= year_c;
               leap_ff <= leap_c;
               doy_ff  <= doy_c;
            end
            default: begin
            end
         endcase
      end
      if (state_ff == S_CAL && rsp_free) begin
         rsp_ff.stamp_out   <= t_ff;
         rsp_ff.year_out    <= year_ff;
         rsp_ff.month_out   <= mon_idx + 4'd1;
         rsp_ff.day_out     <= dom;
         rsp_ff.hour_out    <= hour_ff;
         rsp_ff.minute_out  <= min_ff;
         rsp_ff.second_out  <= sec_ff;
         rsp_ff.milli_out   <= milli_ff;
         rsp_ff.leap_flag   <= leap_ff;
         rsp_ff.day_of_year <= doy_ff;
         rsp_ff.day_count   <= days_ff;
      end
   end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Epoch calendar converter testbench
// Sends decode and compose requests to the converter and compares every
// response with typed-in values or with a calendar model run in the bench.
// Both channels idle at random, with one stretch that has no idling at all.
// ----------------------------------------------------------------------------
module tb;
   import epc_pkg::*;

   logic clock;
   logic reset;

   epc_stream_if #(.item_type(req_item_type)) req_chan ();
   epc_stream_if #(.item_type(rsp_item_type)) rsp_chan ();

   epoch_ms_calendar_converter dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   localparam logic MODE_DECODE  = 1'b0;
   localparam logic MODE_COMPOSE = 1'b1;
   localparam longint unsigned DAY_MS = 64'd86400000;
   localparam longint unsigned MAX_STAMP = 64'd253402300799999;
   localparam int NUM_RANDOM = 1950;

   // Expected responses, oldest first.
   rsp_item_type expected_dates[$];
   int           error_count;
   logic         no_idle;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Days from 1970-01-01 to January 1 of the given year.
   function automatic longint unsigned days_to_year(input longint unsigned y);
      return 365 * (y - 1970) + (y - 1969) / 4 - (y - 1901) / 100 + (y - 1601) / 400;
   endfunction

   function automatic bit leap_year(input longint unsigned y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
   endfunction

   function automatic int first_day(input int m);
      int starts [12];
      starts = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
      return starts[m];
   endfunction

   // Works out the calendar breakdown that one request should produce.
   function automatic rsp_item_type calendar_of(input req_item_type rq);
      rsp_item_type    r;
      longint unsigned t, days, ms_of_day, y, doy, m, d, md;
      int              mi;
      bit              lp;
      int              maxday [12];
      maxday = '{31, 29, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
      if (rq.mode == MODE_DECODE) begin
         t = rq.stamp_in;
      end else begin
         y = rq.year_in;
         m = rq.month_in;
         d = rq.day_in;
         if (y < 1970) y = 1970;
         if (y > 9999) y = 9999;
         if (m < 1 || m > 12) m = 1;
         md = maxday[m - 1];
         if (d < 1 || d > md) d = 1;
         days = days_to_year(y) + first_day(int'(m - 1)) + d - 1;
         if (m > 2) days += leap_year(y);
         t = days * DAY_MS + rq.hour_in * 64'd3600000 + rq.minute_in * 64'd60000
             + rq.second_in * 64'd1000 + rq.milli_in;
         t &= 64'hFFFF_FFFF_FFFF;
      end
      days      = t / DAY_MS;
      ms_of_day = t % DAY_MS;
      y = 1970 + days / 366;
      while (days_to_year(y + 1) <= days) y++;
      doy = days - days_to_year(y);
      lp  = leap_year(y);
      mi  = 11;
      while (mi > 0 && doy < first_day(mi) + (mi >= 2 ? lp : 0)) mi--;
      r.stamp_out   = t[47:0];
      r.year_out    = y[13:0];
      r.month_out   = 4'(mi + 1);
      r.day_out     = 5'(doy - (first_day(mi) + (mi >= 2 ? lp : 0)) + 1);
      r.hour_out    = 5'(ms_of_day / 3600000);
      r.minute_out  = 6'((ms_of_day / 60000) % 60);
      r.second_out  = 6'((ms_of_day / 1000) % 60);
      r.milli_out   = 10'(ms_of_day % 1000);
      r.leap_flag   = lp;
      r.day_of_year = doy[8:0];
      r.day_count   = days[21:0];
      return r;
   endfunction

   function automatic req_item_type decode_req(input longint unsigned s);
      req_item_type rq;
      rq = '0;
      rq.mode = MODE_DECODE;
      rq.stamp_in = s[47:0];
      return rq;
   endfunction

   function automatic req_item_type compose_req(input int y, m, d, h, mn, s, ms);
      req_item_type rq;
      rq = '0;
      rq.mode = MODE_COMPOSE;
      rq.year_in = 14'(y);  rq.month_in = 4'(m);  rq.day_in = 5'(d);
      rq.hour_in = 5'(h);  rq.minute_in = 6'(mn);  rq.second_in = 6'(s);
      rq.milli_in = 10'(ms);
      return rq;
   endfunction

   // One transfer on the request channel, with a random idle gap first.
   // Valid stays high after the transfer until the next call decides
   // whether to idle.
   task automatic send_req(input req_item_type rq);
      if (!no_idle) begin
         while ($urandom_range(99) < 19) begin
            req_chan.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_chan.valid <= 1'b1;
      req_chan.data  <= rq;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      expected_dates.push_back(calendar_of(rq));
   endtask

   // Directed table: the row's expected response is typed in where it is
   // obvious from the calendar, and otherwise taken from the model.
   typedef struct {
      req_item_type rq;
      bit           has_golden;
      rsp_item_type golden;
   } table_row_type;

   table_row_type directed_rows[$];

   task automatic add_row(input req_item_type rq);
      table_row_type row;
      row.rq = rq;
      row.has_golden = 1'b0;
      row.golden = '0;
      directed_rows.push_back(row);
   endtask

   initial begin
      table_row_type row;
      req_item_type  rq;
      int            y;
      req_chan.valid = 1'b0;
      req_chan.data  = '0;
      no_idle        = 1'b0;
      reset          = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Epoch itself, given as a decode and as a compose.
      row.rq = decode_req(0);
      row.has_golden = 1'b1;
      row.golden = '{48'd0, 14'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 10'd0, 1'b0, 9'd0, 22'd0};
      directed_rows.push_back(row);
      row.rq = compose_req(1970, 1, 1, 0, 0, 0, 0);
      directed_rows.push_back(row);
      // Last millisecond of year 9999.
      row.rq = decode_req(MAX_STAMP);
      row.golden = '{48'd253402300799999, 14'd9999, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59,
                     10'd999, 1'b0, 9'd364, 22'd2932896};
      directed_rows.push_back(row);
      add_row(decode_req(64'hFFFF_FFFF_FFFF));        // largest 48-bit stamp
      add_row(compose_req(9999, 12, 31, 23, 59, 59, 999));
      add_row(compose_req(0, 0, 0, 0, 0, 0, 0));       // year below range, bad month/day
      add_row(compose_req(16383, 15, 31, 31, 63, 63, 1023)); // above range, carries
      add_row(compose_req(2000, 2, 29, 12, 0, 0, 0));  // leap day, 400-year leap
      add_row(compose_req(1900 + 100, 3, 1, 0, 0, 0, 0));
      add_row(compose_req(2100, 2, 29, 0, 0, 0, 0));   // February 29 of a common year
      add_row(compose_req(2023, 2, 30, 0, 0, 0, 0));   // February 30 clamps to 1
      add_row(compose_req(2024, 4, 31, 0, 0, 0, 0));   // April 31 clamps to 1
      add_row(compose_req(2024, 13, 15, 0, 0, 0, 0));  // month 13 clamps to January
      add_row(compose_req(2024, 12, 31, 23, 59, 59, 999));
      add_row(compose_req(2400, 12, 31, 0, 0, 0, 0));
      add_row(decode_req(DAY_MS - 1));
      add_row(decode_req(DAY_MS));
      add_row(decode_req(64'h5555_5555_5555));
      add_row(decode_req(64'hAAAA_AAAA_AAAA));
      add_row(compose_req(10922, 10, 21, 21, 42, 42, 682)); // alternating bits
      add_row(compose_req(5461, 5, 10, 10, 21, 21, 341));

      foreach (directed_rows[i]) begin
         send_req(directed_rows[i].rq);
         if (directed_rows[i].has_golden) expected_dates[$] = directed_rows[i].golden;
      end

      for (int n = 0; n < NUM_RANDOM; n++) begin
         no_idle = (n >= 800 && n < 1000);
         case ($urandom_range(9))
            0, 1, 2: rq = decode_req({$urandom_range(32'd59000), $urandom()} % (MAX_STAMP + 1));
            3:       rq = decode_req({$urandom(), $urandom()});
            4: begin
               rq = decode_req({16'($urandom()), $urandom()});
               rq.year_in  = 14'($urandom());                 // ignored fields
               rq.milli_in = 10'($urandom());
            end
            9:       rq = compose_req($urandom(), $urandom(), $urandom(), $urandom(),
                                      $urandom(), $urandom(), $urandom());
            default: begin
               y = ($urandom_range(3) == 0) ? 4 * $urandom_range(2499) : $urandom_range(1970, 9999);
               if (y < 1970) y = 1970 + y % 8000;
               rq = compose_req(y, $urandom_range(1, 12), $urandom_range(1, 31),
                                $urandom_range(23), $urandom_range(59), $urandom_range(59),
                                $urandom_range(999));
               rq.stamp_in = 48'({$urandom(), $urandom()});        // ignored in compose
            end
         endcase
         send_req(rq);
      end
      req_chan.valid <= 1'b0;
      no_idle = 1'b0;

      while (expected_dates.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Response side: random stalls, and a check of every transfer.
   always @(posedge clock) begin
      rsp_item_type exp_r, got;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = rsp_chan.data;
            if (expected_dates.size() == 0) begin
               $display("%0t: unexpected response %p", $realtime, got);
               error_count++;
            end else begin
               exp_r = expected_dates.pop_front();
               if (got !== exp_r) begin
                  $display("%0t: mismatch expected %p actual %p", $realtime, exp_r, got);
                  error_count++;
               end
            end
         end
         rsp_chan.ready <= no_idle || ($urandom_range(99) >= 19);
      end
   end

   initial begin
      error_count = 0;
   end

   // Slowest run: ~2000 items plus stalls; allow far more.
   initial begin
      #20ms;
      $display("CHECKS FAILED");
      $finish;
   end
endmodule
